// ===== rtl/core/alwc_pkg.sv =====
// Shared types and constants for the array list with cursor.
// Used by the storage cell, the read tree and the top level; no dependencies.
`default_nettype none

package alwc_pkg;

    localparam int ALWC_CAPACITY = 128;
    localparam int ALWC_WORD_W   = 32;
    // Number of cells combined by one first-level register of the read tree.
    localparam int ALWC_GROUP    = 64;

    // Broadcast operation applied to every cell in the commit cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [ALWC_WORD_W-1:0] word;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/alwc_cell.sv =====
// One storage cell of the list: holds a word and trades it with its neighbors.
// Depends on alwc_pkg for the command struct and word width.
`default_nettype none

module alwc_cell #(
    parameter int IW  = 7,
    parameter int IDX = 0
) (
    input  logic                            i_clk,
    input  alwc_pkg::t_cell_cmd             i_cmd,
    input  logic [IW-1:0]                   i_idx,
    input  logic [alwc_pkg::ALWC_WORD_W-1:0] i_left,
    input  logic [alwc_pkg::ALWC_WORD_W-1:0] i_right,
    output logic [alwc_pkg::ALWC_WORD_W-1:0] o_data,
    output logic [alwc_pkg::ALWC_WORD_W-1:0] o_rd
);
    import alwc_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [ALWC_WORD_W-1:0] r_data;
    logic [ALWC_WORD_W-1:0] n_data;

    // Insert opens a gap at the index; remove closes the gap at the index.
    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_INSERT: begin
                if (MY_IDX > i_idx) begin
                    n_data = i_left;
                end else if (MY_IDX == i_idx) begin
                    n_data = i_cmd.word;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= i_idx) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (i_idx == MY_IDX) ? r_data : '0;

endmodule

`default_nettype wire

// ===== rtl/core/alwc_or_tree.sv =====
// Two-level registered OR tree that collects the one selected cell word.
// Depends on alwc_pkg for the group size and word width.
`default_nettype none

module alwc_or_tree #(
    parameter int N = alwc_pkg::ALWC_CAPACITY
) (
    input  logic                             i_clk,
    input  logic [alwc_pkg::ALWC_WORD_W-1:0] i_words [N],
    output logic [alwc_pkg::ALWC_WORD_W-1:0] o_word
);
    import alwc_pkg::*;

    localparam int NG = (N + ALWC_GROUP - 1) / ALWC_GROUP;

    logic [ALWC_WORD_W-1:0] n_grp [NG];
    logic [ALWC_WORD_W-1:0] r_grp [NG];
    logic [ALWC_WORD_W-1:0] n_word;
    logic [ALWC_WORD_W-1:0] r_word;

    for (genvar g = 0; g < NG; g++) begin : g_grp
        localparam int LO = g * ALWC_GROUP;
        localparam int HI = (LO + ALWC_GROUP < N) ? (LO + ALWC_GROUP) : N;

        always_comb begin
            n_grp[g] = '0;
            for (int j = LO; j < HI; j++) begin
                n_grp[g] = n_grp[g] | i_words[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_grp[g] <= n_grp[g];
        end
    end

    always_comb begin
        n_word = '0;
        for (int g = 0; g < NG; g++) begin
            n_word = n_word | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== rtl/core/array_list_with_cursor_unit.sv =====
// Array list with cursor: top level. Depends on alwc_pkg, alwc_cell, alwc_or_tree.
// The request is registered at acceptance, the selected word in the read tree's
// group stage and then its final stage, and the result at commit, later if the
// output stalls. A new request is taken only after the last one has committed.
// Reset: the list is empty and there is no cursor; cell contents are not cleared.
`default_nettype none

module array_list_with_cursor_unit #(
    parameter int CAPACITY = alwc_pkg::ALWC_CAPACITY
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Request channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_req_type,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    // Result channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic signed [31:0] o_data_out,
    output logic [7:0]         o_count
);
    import alwc_pkg::*;

    // Index width for a cell, count width that can hold CAPACITY itself, and a
    // compare width wide enough for both the count and the 8-bit position field.
    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_FIRST  = 3'd2,
        REQ_NEXT   = 3'd3,
        REQ_REMOVE = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC
    } t_state;

    t_state r_state;

    // List bookkeeping. The cursor is an index plus a valid flag; a cleared
    // flag stands for "no cursor".
    logic [CW-1:0] r_fill;
    logic [IW-1:0] r_cur;
    logic          r_cur_valid;

    // Decoded request, held from acceptance until the commit cycle.
    t_cell_op               r_op;
    logic [IW-1:0]          r_idx;
    logic [ALWC_WORD_W-1:0] r_word;
    logic                   r_res_ok;
    logic                   r_res_read;
    logic [7:0]             r_res_count;

    // Output register.
    logic                   r_out_valid;
    logic                   r_out_ok;
    logic [ALWC_WORD_W-1:0] r_out_data;
    logic [7:0]             r_out_count;

    // Next values computed from the incoming request word.
    t_cell_op      n_op;
    logic [IW-1:0] n_idx;
    logic          n_ok;
    logic          n_read;
    logic [CW-1:0] n_fill;
    logic [IW-1:0] n_cur;
    logic          n_cur_valid;

    logic [CMPW-1:0] w_pos_ext;
    logic [CMPW-1:0] w_fill_ext;
    logic [CMPW-1:0] w_nfill_ext;
    logic [CW-1:0]   w_cur_ext;
    logic [CW-1:0]   w_cur_inc;
    logic            w_not_full;
    logic            w_accept;
    logic            w_commit;

    t_cell_cmd              w_cmd;
    logic [ALWC_WORD_W-1:0] w_data [CAPACITY];
    logic [ALWC_WORD_W-1:0] w_rd   [CAPACITY];
    logic [ALWC_WORD_W-1:0] w_tree_word;

    assign w_pos_ext   = CMPW'(i_position);
    assign w_fill_ext  = CMPW'(r_fill);
    assign w_nfill_ext = CMPW'(n_fill);
    assign w_cur_ext   = CW'(r_cur);
    assign w_cur_inc   = w_cur_ext + CW'(1);
    assign w_not_full  = (r_fill < CW'(CAPACITY));

    // One request at a time: the input is open only while the block is idle,
    // but a finished result may still sit in the output register.
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_commit = (r_state == S_EXEC) && (!r_out_valid || !i_stall);

    // Request decode. Append is an insert at the fill position. Every read
    // (first, next, remove) uses the same index as the cell operation, so a
    // single index is broadcast to the cells for both.
    always_comb begin
        n_op        = CELL_HOLD;
        n_idx       = '0;
        n_ok        = 1'b0;
        n_read      = 1'b0;
        n_fill      = r_fill;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        case (t_req'(i_req_type))
            REQ_APPEND: begin
                if (w_not_full) begin
                    n_op   = CELL_INSERT;
                    n_idx  = IW'(r_fill);
                    n_ok   = 1'b1;
                    n_fill = r_fill + CW'(1);
                end
            end
            REQ_INSERT: begin
                if (w_not_full && (w_pos_ext <= w_fill_ext)) begin
                    n_op   = CELL_INSERT;
                    n_idx  = IW'(w_pos_ext);
                    n_ok   = 1'b1;
                    n_fill = r_fill + CW'(1);
                end
            end
            REQ_FIRST: begin
                if (r_fill != '0) begin
                    n_idx       = '0;
                    n_ok        = 1'b1;
                    n_read      = 1'b1;
                    n_cur       = '0;
                    n_cur_valid = 1'b1;
                end
            end
            REQ_NEXT: begin
                // Without a cursor, next behaves like first.
                if (!r_cur_valid) begin
                    if (r_fill != '0) begin
                        n_idx       = '0;
                        n_ok        = 1'b1;
                        n_read      = 1'b1;
                        n_cur       = '0;
                        n_cur_valid = 1'b1;
                    end
                end else if (w_cur_inc < r_fill) begin
                    n_idx  = IW'(w_cur_inc);
                    n_ok   = 1'b1;
                    n_read = 1'b1;
                    n_cur  = IW'(w_cur_inc);
                end
            end
            REQ_REMOVE: begin
                // Removing entry zero leaves the list without a cursor.
                if (r_cur_valid && (w_cur_ext < r_fill)) begin
                    n_op   = CELL_REMOVE;
                    n_idx  = r_cur;
                    n_ok   = 1'b1;
                    n_read = 1'b1;
                    n_fill = r_fill - CW'(1);
                    if (r_cur == '0) begin
                        n_cur_valid = 1'b0;
                    end else begin
                        n_cur = r_cur - IW'(1);
                    end
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // State, bookkeeping and output register. The fill count and cursor move
    // at acceptance; the cells move only in the commit cycle, after the read
    // tree has captured the word at the old index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_op        <= CELL_HOLD;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op        <= n_op;
                        r_idx       <= n_idx;
                        r_word      <= i_value;
                        r_res_ok    <= n_ok;
                        r_res_read  <= n_read;
                        r_res_count <= w_nfill_ext[7:0];
                        r_fill      <= n_fill;
                        r_cur       <= n_cur;
                        r_cur_valid <= n_cur_valid;
                        r_state     <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The output register takes a new result in the commit cycle and
            // empties once the result side has taken its word.
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_out_ok    <= r_res_ok;
                r_out_data  <= r_res_read ? w_tree_word : '0;
                r_out_count <= r_res_count;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_cmd.op   = w_commit ? r_op : CELL_HOLD;
    assign w_cmd.word = r_word;

    // The cell chain. Each cell sees its lower neighbor for insert and its
    // upper neighbor for remove; the ends reuse the new word or their own word.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ALWC_WORD_W-1:0] w_left;
        logic [ALWC_WORD_W-1:0] w_right;

        if (k == 0) begin : g_lo
            assign w_left = r_word;
        end else begin : g_lo
            assign w_left = w_data[k-1];
        end

        if (k == CAPACITY - 1) begin : g_hi
            assign w_right = w_data[k];
        end else begin : g_hi
            assign w_right = w_data[k+1];
        end

        alwc_cell #(
            .IW  (IW),
            .IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_idx   (r_idx),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[k]),
            .o_rd    (w_rd[k])
        );
    end

    // Only the cell whose index matches drives a nonzero word into the tree.
    alwc_or_tree #(
        .N (CAPACITY)
    ) u_tree (
        .i_clk   (i_clk),
        .i_words (w_rd),
        .o_word  (w_tree_word)
    );

    assign o_valid    = r_out_valid;
    assign o_ok       = r_out_ok;
    assign o_data_out = $signed(r_out_data);
    assign o_count    = r_out_count;

    // A valid cursor always points at a stored word.
    a_cursor_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (CW'(r_cur) < r_fill))
        else $error("cursor points past the end of the list");

    // The list never holds more words than there are cells (checked in the commit state).
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_fill <= CW'(CAPACITY)))
        else $error("fill count exceeds capacity");

    // A new result word appears only out of the commit state.
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result word loaded outside the commit state");

    // An accepted request word always reaches the read-tree wait states.
    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RD1))
        else $error("accepted request did not start the read");

endmodule

`default_nettype wire

// ===== tb/array_list_with_cursor_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for array_list_with_cursor_unit: directed and random request
// words are checked against a cycle-free list model kept inside the bench.
// Depends on alwc_pkg and the unit under test.
module array_list_with_cursor_unit_tb;
    import alwc_pkg::*;

    localparam int LIST_CAP      = ALWC_CAPACITY;
    // Random request words, not counting reserved types that the unit only refuses.
    localparam int RANDOM_WORDS  = 750;
    // Each third of the random words runs under its own idling pattern.
    localparam int PHASE_LEN     = 250;
    // Cycles allowed after the last expected result for any stray result word to show.
    localparam int SETTLE_CYCLES = 16;
    // Cycle budget for every directed and random word, with a wide margin.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int REPORT_MAX    = 10;

    // Request codes as the unit decodes them; the last three are reserved.
    typedef enum logic [2:0] {
        REQ_APPEND,
        REQ_INSERT,
        REQ_FIRST,
        REQ_NEXT,
        REQ_REMOVE,
        REQ_RSVD5,
        REQ_RSVD6,
        REQ_RSVD7
    } t_req_kind;

    // One request word waiting to be driven, with the idling phase it belongs to
    // and a flag that holds it back until every earlier result has come out.
    typedef struct packed {
        t_req_kind          kind;
        logic [7:0]         pos;
        logic signed [31:0] word;
        logic [1:0]         phase;
        logic               hold;
    } t_list_req;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] data;
        logic [7:0]         count;
    } t_list_result;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               o_stall;
    logic [2:0]         i_req_type = '0;
    logic [7:0]         i_position = '0;
    logic signed [31:0] i_value    = '0;
    logic               o_valid;
    logic               i_stall    = 1'b0;
    logic               o_ok;
    logic signed [31:0] o_data_out;
    logic [7:0]         o_count;

    array_list_with_cursor_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_ok       (o_ok),
        .o_data_out (o_data_out),
        .o_count    (o_count)
    );

    always #1 i_clk = ~i_clk;

    // Bench copy of the list: contents, number of stored words and cursor.
    // A cursor of -1 means there is no current word.
    logic signed [31:0] list_mem [LIST_CAP];
    int                 list_fill   = 0;
    int                 list_cursor = -1;

    t_list_req    pending_requests [$];
    t_list_result awaited_results  [$];
    t_list_req    drive_req;
    t_list_result want;
    logic         req_taken   = 1'b0;
    int           rx_phase    = 0;
    int           fault_count = 0;
    int           cycle_count = 0;
    int           queued_live = 0;

    // Applies one request word to the bench list and returns the result word it
    // must produce. Only entries below list_fill are ever read, so entries that
    // were never written stay out of every result.
    function automatic t_list_result list_step(t_req_kind kind, logic [7:0] pos,
                                               logic signed [31:0] word);
        t_list_result res;
        int           slot;
        res = '0;
        case (kind)
            REQ_APPEND: if (list_fill < LIST_CAP) begin
                list_mem[list_fill] = word;
                list_fill++;
                res.ok = 1'b1;
            end
            // An index equal to the fill level appends; anything above it is refused.
            // The cursor index stays put, so it may now point at the new word.
            REQ_INSERT: if (list_fill < LIST_CAP && int'(pos) <= list_fill) begin
                for (slot = list_fill; slot > int'(pos); slot--)
                    list_mem[slot] = list_mem[slot - 1];
                list_mem[pos] = word;
                list_fill++;
                res.ok = 1'b1;
            end
            REQ_FIRST: if (list_fill > 0) begin
                list_cursor = 0;
                res.data    = list_mem[0];
                res.ok      = 1'b1;
            end
            // With no cursor this steps from -1 to 0, the same as first. At the
            // last word it is refused and the cursor does not move.
            REQ_NEXT: if (list_cursor + 1 < list_fill && list_cursor + 1 >= 0) begin
                list_cursor++;
                res.data = list_mem[list_cursor];
                res.ok   = 1'b1;
            end
            // Removing word 0 leaves the cursor at -1, that is, no cursor.
            REQ_REMOVE: if (list_cursor >= 0 && list_cursor < list_fill) begin
                res.data = list_mem[list_cursor];
                for (slot = list_cursor; slot < list_fill - 1; slot++)
                    list_mem[slot] = list_mem[slot + 1];
                list_fill--;
                list_cursor--;
                res.ok = 1'b1;
            end
            default: ;
        endcase
        res.count = list_fill[7:0];
        return res;
    endfunction

    // Sender and receiver idle percentages for each phase: the sender idles less
    // than the receiver first, then the other way round, then neither idles.
    function automatic int send_gap_pct(int phase);
        return (phase == 0) ? 30 : (phase == 1) ? 74 : 0;
    endfunction

    function automatic int rx_stall_pct(int phase);
        return (phase == 0) ? 74 : (phase == 1) ? 30 : 0;
    endfunction

    // Extremes show up often enough that every bit of the value field toggles
    // and the sign boundary is crossed in both directions.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(t_req_kind kind, int pos, logic [31:0] word, int phase,
                                 bit hold);
        t_list_req rq;
        rq.kind  = kind;
        rq.pos   = pos[7:0];
        rq.word  = word;
        rq.phase = phase[1:0];
        rq.hold  = hold;
        pending_requests.push_back(rq);
        if (kind < REQ_RSVD5)
            queued_live++;
    endtask

    // Driver. Inputs move only on the falling edge. A new word is offered only
    // when the channel is empty or the last word was taken at the rising edge
    // just past, so a stalled word never changes. Valid is decided without
    // looking at o_stall.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || req_taken) begin
                if (pending_requests.size() != 0 &&
                        !(pending_requests[0].hold && awaited_results.size() != 0) &&
                        $urandom_range(99) >= send_gap_pct(pending_requests[0].phase)) begin
                    drive_req = pending_requests.pop_front();
                    rx_phase  = drive_req.phase;
                    i_valid    <= 1'b1;
                    i_req_type <= drive_req.kind;
                    i_position <= drive_req.pos;
                    i_value    <= drive_req.word;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < rx_stall_pct(rx_phase));
        end
    end

    // Monitor. Both channels are sampled on the rising edge. The result side is
    // checked before the request side adds its expectation, so the order of the
    // two within one edge never matters.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (awaited_results.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("Unexpected result word: ok=%0d data=%0d count=%0d",
                                 o_ok, o_data_out, o_count);
                end else begin
                    want = awaited_results.pop_front();
                    if (o_ok !== want.ok || o_data_out !== want.data ||
                            o_count !== want.count) begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display({"Result mismatch: expected ok=%0d data=%0d count=%0d, ",
                                      "got ok=%0d data=%0d count=%0d"},
                                     want.ok, want.data, want.count,
                                     o_ok, o_data_out, o_count);
                    end
                end
            end
            if (i_valid && !o_stall)
                awaited_results.push_back(list_step(t_req_kind'(i_req_type), i_position,
                                                    i_value));
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int  est_fill;
        int  full_tries;
        int  drain_floor;
        int  last_phase;
        int  phase;
        int  r;
        int  pos_pick;
        bit  growing;
        bit  hold;

        // Directed words, all under the first idling pattern.
        // Empty list: first, next and remove are all refused, and an insert
        // index past the end is refused.
        queue_request(REQ_FIRST, $urandom_range(255), rand_word(), 0, 0);
        queue_request(REQ_NEXT, $urandom_range(255), rand_word(), 0, 0);
        queue_request(REQ_REMOVE, $urandom_range(255), rand_word(), 0, 0);
        queue_request(REQ_INSERT, 1, 32'h1111_1111, 0, 0);
        // Build six words with the value extremes, inserts in the middle and at the end.
        queue_request(REQ_INSERT, 0, 32'h8000_0000, 0, 0);
        queue_request(REQ_APPEND, $urandom_range(255), 32'h7FFF_FFFF, 0, 0);
        queue_request(REQ_APPEND, $urandom_range(255), 32'h0000_0000, 0, 0);
        queue_request(REQ_APPEND, $urandom_range(255), 32'hFFFF_FFFF, 0, 0);
        queue_request(REQ_INSERT, 2, 32'h5A5A_A5A5, 0, 0);
        queue_request(REQ_INSERT, 5, 32'h1234_5678, 0, 0);
        // Highest index the field allows, far past the end.
        queue_request(REQ_INSERT, 255, rand_word(), 0, 0);
        // Next without a cursor acts as first, then first itself.
        queue_request(REQ_NEXT, $urandom_range(255), rand_word(), 0, 0);
        queue_request(REQ_FIRST, $urandom_range(255), rand_word(), 0, 0);
        // Insert at 0 keeps the cursor index, so it now sits on the new word.
        queue_request(REQ_INSERT, 0, 32'hC0DE_F00D, 0, 0);
        // Remove word 0 drops the cursor; a second remove is then refused.
        queue_request(REQ_REMOVE, $urandom_range(255), rand_word(), 0, 0);
        queue_request(REQ_REMOVE, $urandom_range(255), rand_word(), 0, 0);
        // Walk the whole list, one step past the last word, then remove the last.
        for (int n = 0; n < 7; n++)
            queue_request(REQ_NEXT, $urandom_range(255), rand_word(), 0, 0);
        queue_request(REQ_REMOVE, $urandom_range(255), rand_word(), 0, 0);
        queue_request(REQ_RSVD5, 8'hFF, rand_word(), 0, 0);
        queue_request(REQ_RSVD6, $urandom_range(255), rand_word(), 0, 0);
        queue_request(REQ_RSVD7, $urandom_range(255), rand_word(), 0, 0);

        // Random part. The generator keeps only a rough count of stored words: it
        // alternates between filling the list until appends and inserts hit the full limit and
        // draining it with next-then-remove pairs, which delete one word whenever
        // the list is not empty. The first word of each idling phase is held back
        // until the unit has delivered every result owed so far.
        queued_live = 0;
        est_fill    = 5;
        full_tries  = 0;
        drain_floor = 0;
        growing     = 1'b1;
        last_phase  = -1;
        while (queued_live < RANDOM_WORDS) begin
            phase = (queued_live < PHASE_LEN) ? 0 : (queued_live < 2 * PHASE_LEN) ? 1 : 2;
            hold  = (phase != last_phase);
            last_phase = phase;
            r = $urandom_range(99);
            if (growing) begin
                if (r < 55) begin
                    queue_request(REQ_APPEND, $urandom_range(255), rand_word(), phase, hold);
                    if (est_fill < LIST_CAP) est_fill++;
                    else full_tries++;
                end else if (r < 85) begin
                    pos_pick = (r < 82) ? $urandom_range(0, est_fill) : $urandom_range(255);
                    queue_request(REQ_INSERT, pos_pick, rand_word(), phase, hold);
                    if (pos_pick <= est_fill) begin
                        if (est_fill < LIST_CAP) est_fill++;
                        else full_tries++;
                    end
                end else if (r < 90) begin
                    queue_request(REQ_FIRST, $urandom_range(255), rand_word(), phase, hold);
                end else if (r < 95) begin
                    queue_request(REQ_NEXT, $urandom_range(255), rand_word(), phase, hold);
                end else if (r < 98) begin
                    queue_request(REQ_REMOVE, $urandom_range(255), rand_word(), phase, hold);
                    if (est_fill > 0) est_fill--;
                end else begin
                    queue_request(t_req_kind'($urandom_range(5, 7)), $urandom_range(255),
                                  rand_word(), phase, hold);
                end
                if (full_tries >= 6)
                    growing = 1'b0;
            end else begin
                if (r < 70) begin
                    queue_request(REQ_NEXT, $urandom_range(255), rand_word(), phase, hold);
                    queue_request(REQ_REMOVE, $urandom_range(255), rand_word(), phase, 0);
                    if (est_fill > 0) est_fill--;
                end else if (r < 78) begin
                    queue_request(REQ_FIRST, $urandom_range(255), rand_word(), phase, hold);
                end else if (r < 85) begin
                    queue_request(REQ_APPEND, $urandom_range(255), rand_word(), phase, hold);
                    if (est_fill < LIST_CAP) est_fill++;
                end else if (r < 92) begin
                    pos_pick = $urandom_range(255);
                    queue_request(REQ_INSERT, pos_pick, rand_word(), phase, hold);
                    if (pos_pick <= est_fill && est_fill < LIST_CAP) est_fill++;
                end else begin
                    queue_request(t_req_kind'($urandom_range(5, 7)), $urandom_range(255),
                                  rand_word(), phase, hold);
                end
                if (est_fill <= drain_floor) begin
                    growing     = 1'b1;
                    full_tries  = 0;
                    drain_floor = $urandom_range(12);
                end
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Run until every word is taken and every result has come back, then give
        // the unit a few more cycles to show any stray result.
        while (pending_requests.size() != 0 || i_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && awaited_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
